[rtl/abzsc_pkg.sv]
// ----------------------------------------------------------------------------
// abzsc_pkg
// Shared types, constants and the CRC-32 byte step for the byte stream cipher.
// ----------------------------------------------------------------------------
package abzsc_pkg;

   // key schedule constants
   localparam logic [31:0] KEY_MUL_CONST  = 32'h0808_8405;
   localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
   localparam logic [31:0] INIT_KEY_A_RST = 32'h1234_5678;
   localparam logic [31:0] INIT_KEY_B_RST = 32'h2345_6789;
   localparam logic [31:0] INIT_KEY_C_RST = 32'h3456_7890;

   // beat modes
   typedef enum logic [1:0] {
      MODE_DECRYPT  = 2'd0,
      MODE_ENCRYPT  = 2'd1,
      MODE_PASSWORD = 2'd2,
      MODE_UNUSED   = 2'd3
   } mode_type;

   // register indexes
   typedef enum logic [1:0] {
      CSR_ENABLE     = 2'd0,
      CSR_INIT_KEY_A = 2'd1,
      CSR_INIT_KEY_B = 2'd2,
      CSR_INIT_KEY_C = 2'd3
   } csr_index_type;

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_KS    = 6'b000010,
      ST_CRCA  = 6'b000100,
      ST_MULB  = 6'b001000,
      ST_CRCC  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   // operand select for the shared multiplier
   typedef struct packed {
      logic key_b_step;   // 1: key_b times constant, 0: keystream product t * (t ^ 1)
   } mul_ctrl_type;

   // one entry of the reflected crc-32 table
   function automatic logic [31:0] crc_table(input logic [7:0] idx);
      logic [31:0] c;
      c = {24'd0, idx};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // crc-32 update by one byte
   function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
      return {8'd0, crc[31:8]} ^ crc_table(crc[7:0] ^ b);
   endfunction

endpackage

[rtl/abzsc_mul_unit.sv]
// ----------------------------------------------------------------------------
// abzsc_mul_unit
// Shared 32x32 multiplier (low word) serving the keystream and key_b update.
// ----------------------------------------------------------------------------
module abzsc_mul_unit (
   input  abzsc_pkg::mul_ctrl_type ctrl,
   input  logic [31:0]             key_b,
   input  logic [31:0]             key_c,
   output logic [31:0]             product
);
   import abzsc_pkg::*;

   logic [15:0] ks_t;
   logic [31:0] op_a;
   logic [31:0] op_b;

   // keystream operand: low half of key_c with bit one forced high
   assign ks_t = {key_c[15:2], 1'b1, key_c[0]};

   // operand selection
   always_comb begin
      if (ctrl.key_b_step) begin
         op_a = key_b;
         op_b = KEY_MUL_CONST;
      end else begin
         op_a = {16'd0, ks_t};
         op_b = {16'd0, ks_t ^ 16'd1};
      end
   end

   assign product = op_a * op_b;

endmodule

[rtl/alternate_byte_zip_stream_cipher.sv]
// ----------------------------------------------------------------------------
// alternate_byte_zip_stream_cipher
// Traditional zip-style byte stream cipher with three 32-bit keys; when enabled,
// even position bytes are transformed, odd ones pass, password beats feed the keys.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  data_byte, mode, start_of_file
//  rsp      out        rsp_valid/rsp_ready  out_byte
//  csr      in         csr_write_en         csr_index, csr_write_data
//
// one beat at a time; after the accept cycle a transformed byte passes through
// keystream multiply, key_a crc, key_b multiply and key_c crc (the multiplies
// on the shared multiplier), then waits in the output register until taken.
// pass-through bytes are presented the cycle after accept; a password beat
// frees the input after key_a crc, key_b multiply and key_c crc,
// or at once when the cipher is disabled.
// synchronous active-high reset loads the init keys with their reset values.
// ----------------------------------------------------------------------------
module alternate_byte_zip_stream_cipher (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic [1:0]  req_mode,
   input  logic        req_start_of_file,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   // register write port
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import abzsc_pkg::*;

   state_type    state_ff, state_in;
   logic         enable_ff;
   logic [31:0]  init_a_ff, init_b_ff, init_c_ff;
   logic [31:0]  key_a_ff, key_a_in;
   logic [31:0]  key_b_ff, key_b_in;
   logic [31:0]  key_c_ff, key_c_in;
   logic         odd_ff, odd_in;
   logic [1:0]   mode_ff, mode_in;
   logic [7:0]   out_ff, out_in;
   logic [7:0]   absorb_ff, absorb_in;
   mul_ctrl_type mul_ctrl;
   logic [31:0]  mul_out;
   logic [31:0]  crc_a;
   logic         odd_eff;
   logic [7:0]   ks_byte;

   // shared multiplier
   assign mul_ctrl.key_b_step = (state_ff == ST_MULB);

   abzsc_mul_unit u_mul (
      .ctrl    (mul_ctrl),
      .key_b   (key_b_ff),
      .key_c   (key_c_ff),
      .product (mul_out)
   );

   assign ks_byte  = mul_out[15:8];
   assign crc_a    = crc_step(key_a_ff, absorb_ff);
   assign odd_eff  = req_start_of_file ? 1'b0 : odd_ff;

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = (state_ff == ST_OUT);
   assign rsp_out_byte = out_ff;

   // sequencer and datapath next values
   always_comb begin
      state_in  = state_ff;
      key_a_in  = key_a_ff;
      key_b_in  = key_b_ff;
      key_c_in  = key_c_ff;
      odd_in    = odd_ff;
      mode_in   = mode_ff;
      out_in    = out_ff;
      absorb_in = absorb_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in   = req_mode;
               out_in    = req_data_byte;
               absorb_in = req_data_byte;
               if (req_start_of_file) begin
                  key_a_in = init_a_ff;
                  key_b_in = init_b_ff;
                  key_c_in = init_c_ff;
                  odd_in   = 1'b0;
               end
               case (req_mode)
                  MODE_PASSWORD: begin
                     if (enable_ff) begin
                        state_in = ST_CRCA;
                     end
                  end
                  MODE_DECRYPT, MODE_ENCRYPT: begin
                     odd_in   = !odd_eff;
                     state_in = (enable_ff && !odd_eff) ? ST_KS : ST_OUT;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_KS: begin
            out_in    = out_ff ^ ks_byte;
            absorb_in = (mode_ff == MODE_DECRYPT) ? (out_ff ^ ks_byte) : out_ff;
            state_in  = ST_CRCA;
         end
         ST_CRCA: begin
            key_a_in = crc_a;
            key_b_in = key_b_ff + {24'd0, crc_a[7:0]};
            state_in = ST_MULB;
         end
         ST_MULB: begin
            key_b_in = mul_out + 32'd1;
            state_in = ST_CRCC;
         end
         ST_CRCC: begin
            key_c_in = crc_step(key_c_ff, key_b_ff[31:24]);
            state_in = (mode_ff == MODE_PASSWORD) ? ST_IDLE : ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         key_a_ff <= INIT_KEY_A_RST;
         key_b_ff <= INIT_KEY_B_RST;
         key_c_ff <= INIT_KEY_C_RST;
         odd_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         key_a_ff <= key_a_in;
         key_b_ff <= key_b_in;
         key_c_ff <= key_c_in;
         odd_ff   <= odd_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      out_ff    <= out_in;
      absorb_ff <= absorb_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         init_a_ff <= INIT_KEY_A_RST;
         init_b_ff <= INIT_KEY_B_RST;
         init_c_ff <= INIT_KEY_C_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ENABLE:     enable_ff <= csr_write_data[0];
            CSR_INIT_KEY_A: init_a_ff <= csr_write_data;
            CSR_INIT_KEY_B: init_b_ff <= csr_write_data;
            CSR_INIT_KEY_C: init_c_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   // input and output never open together
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while a result is pending");

   // unused mode echoes the byte on the next cycle
   a_unused_echo: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_UNUSED)
      |=> (rsp_valid && rsp_out_byte == $past(req_data_byte)))
      else $error("unused mode did not echo the byte");

   // disabled password beat without a restart leaves the block idle
   a_pw_disabled: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_PASSWORD && !enable_ff
       && !req_start_of_file)
      |=> (req_ready && $stable(key_a_ff) && $stable(key_c_ff)))
      else $error("disabled password beat changed state");

   // taken result frees the input on the next cycle
   a_rsp_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready)
      else $error("input not released after result taken");

   // odd position toggles on every accepted cipher beat without a restart
   a_odd_toggle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_start_of_file
       && (req_mode == MODE_DECRYPT || req_mode == MODE_ENCRYPT))
      |=> (odd_ff != $past(odd_ff)))
      else $error("odd position did not toggle");
`endif

endmodule

[bench/tb_alternate_byte_zip_stream_cipher.sv]
// ----------------------------------------------------------------------------
// tb_alternate_byte_zip_stream_cipher
// Self-checking bench for the zip-style byte stream cipher. A driver offers
// beats from a queue and predicts each accepted beat with its own copy of the
// keys and parity. A monitor compares every output byte with the oldest
// prediction. The run starts with a directed part, then moves through several
// register settings with random file-shaped streams and random noise, under
// varying backpressure.
// ----------------------------------------------------------------------------
module tb_alternate_byte_zip_stream_cipher;
   timeunit 1ns;
   timeprecision 1ps;

   import abzsc_pkg::*;

   localparam int CYCLE_LIMIT      = 400_000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int BEATS_PER_PHASE  = 325;
   localparam int PHASE_COUNT      = 6;
   localparam int MAX_REPORT_LINES = 200;

   // one request beat
   typedef struct packed {
      logic [7:0] data_byte;
      mode_type   mode;
      logic       start_of_file;
   } cipher_beat_type;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte     = 8'd0;
   logic [1:0]  req_mode          = MODE_DECRYPT;
   logic        req_start_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        csr_write_en      = 1'b0;
   logic [1:0]  csr_index         = CSR_ENABLE;
   logic [31:0] csr_write_data    = 32'd0;

   cipher_beat_type pending_beats[$];
   cipher_beat_type held_beat;
   logic [7:0]      expected_bytes[$];
   logic [7:0]      want_byte;

   int send_idle_pct  = 25;
   int recv_stall_pct = 51;
   int mismatch_count = 0;
   int cycle_count    = 0;

   // predictor copy of the registers and the cipher state
   logic        cfg_enable = 1'b1;
   logic [31:0] cfg_key_a  = INIT_KEY_A_RST;
   logic [31:0] cfg_key_b  = INIT_KEY_B_RST;
   logic [31:0] cfg_key_c  = INIT_KEY_C_RST;
   logic [31:0] key_a      = INIT_KEY_A_RST;
   logic [31:0] key_b      = INIT_KEY_B_RST;
   logic [31:0] key_c      = INIT_KEY_C_RST;
   logic        odd_pos    = 1'b0;

   alternate_byte_zip_stream_cipher dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_mode          (req_mode),
      .req_start_of_file (req_start_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #2 clock = ~clock;

   // reflected crc-32, one bit at a time
   function automatic logic [31:0] crc_byte_update(input logic [31:0] crc,
                                                   input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // fold a plaintext byte into the three keys
   task automatic absorb_plain(input logic [7:0] plain);
      key_a = crc_byte_update(key_a, plain);
      key_b = KEY_MUL_CONST * (key_b + {24'd0, key_a[7:0]}) + 32'd1;
      key_c = crc_byte_update(key_c, key_b[31:24]);
   endtask

   // expected output for one accepted beat
   task automatic predict_cipher_beat(input cipher_beat_type b);
      logic [15:0] t;
      logic [31:0] prod;
      logic [7:0]  result;
      result = b.data_byte;
      if (b.start_of_file) begin
         key_a   = cfg_key_a;
         key_b   = cfg_key_b;
         key_c   = cfg_key_c;
         odd_pos = 1'b0;
      end
      case (b.mode)
         MODE_PASSWORD: begin
            if (cfg_enable) absorb_plain(b.data_byte);
         end
         MODE_UNUSED: begin
            expected_bytes.push_back(b.data_byte);
         end
         default: begin
            if (cfg_enable && !odd_pos) begin
               t      = (key_c[15:0] & 16'hFFFD) | 16'h0002;
               prod   = {16'd0, t} * {16'd0, t ^ 16'h0001};
               result = b.data_byte ^ prod[15:8];
               absorb_plain((b.mode == MODE_DECRYPT) ? result : b.data_byte);
            end
            odd_pos = ~odd_pos;
            expected_bytes.push_back(result);
         end
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      // printing stops after a while, counting does not
      if (mismatch_count < MAX_REPORT_LINES) $display("ERROR @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic push_beat(input logic [7:0] data, input mode_type m, input logic sof);
      cipher_beat_type b;
      b.data_byte     = data;
      b.mode          = m;
      b.start_of_file = sof;
      pending_beats.push_back(b);
   endtask

   // mostly well-formed files: password beats, then a body mostly in one mode
   task automatic queue_random_stream(input int n);
      int       made;
      int       pw_len;
      int       body_len;
      mode_type body_mode;
      mode_type other_mode;
      made = 0;
      while (made < n) begin
         if ($urandom_range(99) < 80) begin
            pw_len     = $urandom_range(8);
            body_len   = $urandom_range(40, 1);
            body_mode  = ($urandom_range(1) == 0) ? MODE_DECRYPT : MODE_ENCRYPT;
            other_mode = (body_mode == MODE_DECRYPT) ? MODE_ENCRYPT : MODE_DECRYPT;
            for (int i = 0; i < pw_len; i++) begin
               push_beat(8'($urandom_range(255)), MODE_PASSWORD, i == 0);
            end
            for (int i = 0; i < body_len; i++) begin
               push_beat(8'($urandom_range(255)),
                         ($urandom_range(9) == 0) ? other_mode : body_mode,
                         (pw_len == 0) && (i == 0));
            end
            made += pw_len + body_len;
         end else begin
            // noise beat, any mode, occasional restart
            push_beat(8'($urandom_range(255)), mode_type'($urandom_range(3)),
                      $urandom_range(3) == 0);
            made++;
         end
      end
   endtask

   // write one register at the next edge and mirror it in the predictor
   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
      case (idx)
         CSR_ENABLE:     cfg_enable = value[0];
         CSR_INIT_KEY_A: cfg_key_a  = value;
         CSR_INIT_KEY_B: cfg_key_b  = value;
         CSR_INIT_KEY_C: cfg_key_c  = value;
         default: begin
         end
      endcase
   endtask

   // all queued beats taken, all bytes back, then a settle wait for password work
   task automatic wait_until_drained();
      do @(posedge clock);
      while (pending_beats.size() != 0 || req_valid || expected_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_cipher_beat(held_beat);
         end
         if (!req_valid || req_ready) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               held_beat = pending_beats.pop_front();
               req_valid         <= 1'b1;
               req_data_byte     <= held_beat.data_byte;
               req_mode          <= held_beat.mode;
               req_start_of_file <= held_beat.start_of_file;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("out_byte %02h with nothing expected", rsp_out_byte));
            end else begin
               want_byte = expected_bytes.pop_front();
               if (rsp_out_byte !== want_byte) begin
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_out_byte, want_byte));
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("alternate_byte_zip_stream_cipher test failed");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      logic [31:0] set_value[4];

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed beats under the reset register values
      push_beat(8'h00, MODE_PASSWORD, 1'b1);
      push_beat(8'hFF, MODE_PASSWORD, 1'b0);
      push_beat(8'h5A, MODE_PASSWORD, 1'b0);
      push_beat(8'h00, MODE_DECRYPT,  1'b0);
      push_beat(8'hFF, MODE_DECRYPT,  1'b0);
      push_beat(8'hFF, MODE_ENCRYPT,  1'b0);
      push_beat(8'h00, MODE_ENCRYPT,  1'b0);
      push_beat(8'hA5, MODE_UNUSED,   1'b0);
      push_beat(8'h3C, MODE_DECRYPT,  1'b0);
      push_beat(8'h80, MODE_ENCRYPT,  1'b1);
      push_beat(8'h01, MODE_ENCRYPT,  1'b0);
      push_beat(8'h7F, MODE_DECRYPT,  1'b1);
      push_beat(8'hC3, MODE_UNUSED,   1'b1);
      push_beat(8'h55, MODE_DECRYPT,  1'b0);
      push_beat(8'hAA, MODE_DECRYPT,  1'b0);
      push_beat(8'h12, MODE_PASSWORD, 1'b1);
      push_beat(8'h34, MODE_ENCRYPT,  1'b0);
      push_beat(8'hFE, MODE_ENCRYPT,  1'b0);
      push_beat(8'h99, MODE_PASSWORD, 1'b0);
      push_beat(8'h0F, MODE_DECRYPT,  1'b0);
      wait_until_drained();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         // register setting per phase, extremes first
         case (ph)
            0: set_value = '{32'h0000_0001, 32'h0, 32'h0, 32'h0};
            1: set_value = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            2: set_value = '{32'h0000_0003, $urandom, $urandom, $urandom};
            3: set_value = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0, $urandom};
            4: set_value = '{32'hFFFF_FFFE, $urandom, $urandom, $urandom};
            default: set_value = '{32'h0000_0001, $urandom, 32'hFFFF_FFFF, 32'h0};
         endcase
         for (int i = 0; i < 4; i++) begin
            write_csr(csr_index_type'(i), set_value[i]);
         end
         csr_write_en <= 1'b0;

         // idling: sender light then heavy, then none at all
         if (ph < 2) begin
            send_idle_pct  = 25;
            recv_stall_pct = 51;
         end else if (ph < 4) begin
            send_idle_pct  = 51;
            recv_stall_pct = 25;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end

         queue_random_stream(BEATS_PER_PHASE);
         wait_until_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         report_mismatch($sformatf("%0d expected bytes never came", expected_bytes.size()));
      end
      if (mismatch_count == 0) begin
         $display("alternate_byte_zip_stream_cipher test passed");
      end else begin
         $display("alternate_byte_zip_stream_cipher test failed");
      end
      $finish;
   end

endmodule
